// ===== hw/rtl/websocket_frame_deframer_top_macros.svh =====
// ---------------------------------------------------------------------------
// WebSocket deframer assertion macros
// Shared concurrent assertion forms. They compile away when ASSERT_OFF is set.
// ---------------------------------------------------------------------------
`ifndef WEBSOCKET_FRAME_DEFRAMER_TOP_MACROS_SVH
`define WEBSOCKET_FRAME_DEFRAMER_TOP_MACROS_SVH

`ifndef ASSERT_OFF
// same-cycle implication
`define WSD_ASSERT_IMP(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("websocket deframer: same-cycle check failed");
// next-cycle implication
`define WSD_ASSERT_NXT(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("websocket deframer: next-cycle check failed");
`else
`define WSD_ASSERT_IMP(lbl, clk, rst, ante, cons)
`define WSD_ASSERT_NXT(lbl, clk, rst, ante, cons)
`endif

`endif

// ===== hw/rtl/wsd_pkg.sv =====
// ---------------------------------------------------------------------------
// WebSocket deframer package
// Phase and status codes, the result beat type and length limits.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package wsd_pkg;

   // width of the payload length counter after saturation (16 to 64)
   localparam int LENGTH_BITS = 64;
   localparam logic [63:0] LEN_MAX = (LENGTH_BITS >= 64) ? 64'hFFFF_FFFF_FFFF_FFFF :
                                     ((64'd1 << LENGTH_BITS) - 64'd1);

   localparam logic [3:0] WS_TEXT   = 4'h1;
   localparam logic [6:0] LEN7_EXT16 = 7'd126;
   localparam logic [6:0] LEN7_EXT64 = 7'd127;
   localparam logic [3:0] EXT16_BYTES = 4'd2;
   localparam logic [3:0] EXT64_BYTES = 4'd8;
   localparam logic [3:0] KEY_BYTES   = 4'd4;

   typedef enum logic [2:0] {
      PH_HDR0  = 3'd0,
      PH_HDR1  = 3'd1,
      PH_EXT16 = 3'd2,
      PH_EXT64 = 3'd3,
      PH_KEY   = 3'd4,
      PH_DATA  = 3'd5
   } phase_type;

   typedef enum logic [1:0] {
      ST_TEXT  = 2'd0,
      ST_EMPTY = 2'd1,
      ST_DROP  = 2'd2
   } status_type;

   typedef struct packed {
      logic [7:0] payload_byte;
      logic       end_of_frame;
      logic       final_fragment;
      status_type frame_status;
   } result_type;

   // clamp an extended length to the counter range
   function automatic logic [63:0] sat_len(input logic [63:0] value);
      return (value > LEN_MAX) ? LEN_MAX : value;
   endfunction

endpackage

`default_nettype wire

// ===== hw/rtl/wsd_in_stage.sv =====
// ---------------------------------------------------------------------------
// WebSocket deframer input stage
// Registers one received byte and hands it to the parser.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module wsd_in_stage (
   input  wire logic       clock,
   input  wire logic       reset,
   input  wire logic       req_tvalid,
   output logic            req_tready,
   input  wire logic [7:0] req_tdata,   // [7:0] data_byte
   input  wire logic       step_en,
   output logic            byte_valid,
   output logic [7:0]      byte_data
);

   logic       valid_ff, valid_in;
   logic [7:0] data_ff;
   logic       take;

   // take a beat when empty or when the held byte moves on this cycle
   assign req_tready = !reset && (!valid_ff || step_en);
   assign take       = req_tvalid && req_tready;

   always_comb begin
      if (take) begin
         valid_in = 1'b1;
      end else if (step_en) begin
         valid_in = 1'b0;
      end else begin
         valid_in = valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   // hold the byte payload
   always_ff @(posedge clock) begin
      if (take) begin
         data_ff <= req_tdata;
      end
   end

   assign byte_valid = valid_ff;
   assign byte_data  = data_ff;

endmodule

`default_nettype wire

// ===== hw/rtl/wsd_parser.sv =====
// ---------------------------------------------------------------------------
// WebSocket deframer parser
// Frame header state machine, length counter and payload unmasking.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
`include "websocket_frame_deframer_top_macros.svh"

module wsd_parser (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             step_en,
   input  wire logic [7:0]       byte_data,
   output logic                  res_valid,
   output wsd_pkg::result_type   res
);
   import wsd_pkg::*;

   phase_type   phase_ff, phase_in;
   logic        fin_ff, fin_in;
   logic [3:0]  opcode_ff, opcode_in;
   logic        masked_ff, masked_in;
   logic [3:0]  hcount_ff, hcount_in;
   logic [63:0] remain_ff, remain_in;
   logic [31:0] key_ff, key_in;
   logic [1:0]  kidx_ff, kidx_in;

   logic        len_done;
   logic        hdr_done;
   logic        res_hit;
   logic [3:0]  cnt_next;
   logic [63:0] len_acc;
   logic [7:0]  key_byte;
   logic        last_byte;

   assign cnt_next  = hcount_ff + 4'd1;
   assign len_acc   = {remain_ff[55:0], byte_data};
   assign last_byte = (remain_ff == 64'd1);

   // pick the key byte for this payload position, first key byte on top
   always_comb begin
      case (kidx_ff)
         2'd0:    key_byte = key_ff[31:24];
         2'd1:    key_byte = key_ff[23:16];
         2'd2:    key_byte = key_ff[15:8];
         default: key_byte = key_ff[7:0];
      endcase
   end

   // next state and result for the held byte
   always_comb begin
      phase_in  = phase_ff;
      fin_in    = fin_ff;
      opcode_in = opcode_ff;
      masked_in = masked_ff;
      hcount_in = hcount_ff;
      remain_in = remain_ff;
      key_in    = key_ff;
      kidx_in   = kidx_ff;
      len_done  = 1'b0;
      hdr_done  = 1'b0;
      res_hit   = 1'b0;
      res.payload_byte   = 8'd0;
      res.end_of_frame   = 1'b0;
      res.final_fragment = fin_ff;
      res.frame_status   = ST_TEXT;

      case (phase_ff)
         PH_HDR1: begin
            masked_in = byte_data[7];
            remain_in = 64'd0;
            hcount_in = 4'd0;
            if (byte_data[6:0] == LEN7_EXT64) begin
               phase_in = PH_EXT64;
            end else if (byte_data[6:0] == LEN7_EXT16) begin
               phase_in = PH_EXT16;
            end else begin
               remain_in = {57'd0, byte_data[6:0]};
               len_done  = 1'b1;
            end
         end
         PH_EXT16, PH_EXT64: begin
            remain_in = len_acc;
            hcount_in = cnt_next;
            if (cnt_next >= ((phase_ff == PH_EXT16) ? EXT16_BYTES : EXT64_BYTES)) begin
               remain_in = sat_len(len_acc);
               len_done  = 1'b1;
            end
         end
         PH_KEY: begin
            key_in    = {key_ff[23:0], byte_data};
            hcount_in = cnt_next;
            if (cnt_next >= KEY_BYTES) begin
               hdr_done = 1'b1;
            end
         end
         PH_DATA: begin
            kidx_in   = kidx_ff + 2'd1;
            remain_in = remain_ff - 64'd1;
            if (last_byte) begin
               phase_in = PH_HDR0;
            end
            if (opcode_ff == WS_TEXT) begin
               res_hit          = 1'b1;
               res.payload_byte = byte_data ^ (masked_ff ? key_byte : 8'd0);
               res.end_of_frame = last_byte;
            end else if (last_byte) begin
               res_hit          = 1'b1;
               res.end_of_frame = 1'b1;
               res.frame_status = ST_DROP;
            end
         end
         default: begin
            fin_in    = byte_data[7];
            opcode_in = byte_data[3:0];
            phase_in  = PH_HDR1;
         end
      endcase

      // length known: fetch the key or close the header
      if (len_done) begin
         hcount_in = 4'd0;
         if (masked_in) begin
            phase_in = PH_KEY;
            key_in   = 32'd0;
         end else begin
            hdr_done = 1'b1;
         end
      end

      // header complete: enter payload or close an empty frame now
      if (hdr_done) begin
         kidx_in   = 2'd0;
         hcount_in = 4'd0;
         if (remain_in != 64'd0) begin
            phase_in = PH_DATA;
         end else begin
            phase_in         = PH_HDR0;
            res_hit          = 1'b1;
            res.end_of_frame = 1'b1;
            res.frame_status = (opcode_ff == WS_TEXT) ? ST_EMPTY : ST_DROP;
         end
      end
   end

   assign res_valid = step_en && res_hit;

   // advance parse state once per byte
   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff  <= PH_HDR0;
         fin_ff    <= 1'b0;
         opcode_ff <= 4'd0;
         masked_ff <= 1'b0;
         hcount_ff <= 4'd0;
         remain_ff <= 64'd0;
         key_ff    <= 32'd0;
         kidx_ff   <= 2'd0;
      end else if (step_en) begin
         phase_ff  <= phase_in;
         fin_ff    <= fin_in;
         opcode_ff <= opcode_in;
         masked_ff <= masked_in;
         hcount_ff <= hcount_in;
         remain_ff <= remain_in;
         key_ff    <= key_in;
         kidx_ff   <= kidx_in;
      end
   end

   `WSD_ASSERT_IMP(a_data_len_nonzero, clock, reset, phase_ff == PH_DATA, remain_ff != 64'd0)
   `WSD_ASSERT_IMP(a_key_count_range, clock, reset, phase_ff == PH_KEY, hcount_ff < KEY_BYTES)
   `WSD_ASSERT_NXT(a_status_ends_frame, clock, reset, res_valid && res.frame_status != ST_TEXT, phase_ff == PH_HDR0)

endmodule

`default_nettype wire

// ===== hw/rtl/wsd_out_stage.sv =====
// ---------------------------------------------------------------------------
// WebSocket deframer output stage
// Result register that drives the response stream.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module wsd_out_stage (
   input  wire logic                clock,
   input  wire logic                reset,
   input  wire logic                res_valid,
   input  wire wsd_pkg::result_type res,
   output logic                     rsp_tvalid,
   input  wire logic                rsp_tready,
   output logic [7:0]               rsp_tdata,  // [7:0] payload_byte
   output logic                     rsp_tlast,  // end_of_frame
   output logic [2:0]               rsp_tuser   // [0] final_fragment, [2:1] frame_status
);
   import wsd_pkg::*;

   logic       valid_ff, valid_in;
   result_type res_ff;

   // load a new result, else drop the beat once taken
   always_comb begin
      if (res_valid) begin
         valid_in = 1'b1;
      end else if (rsp_tready) begin
         valid_in = 1'b0;
      end else begin
         valid_in = valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (res_valid) begin
         res_ff <= res;
      end
   end

   assign rsp_tvalid = valid_ff;
   assign rsp_tdata  = res_ff.payload_byte;
   assign rsp_tlast  = res_ff.end_of_frame;
   assign rsp_tuser  = {res_ff.frame_status, res_ff.final_fragment};

endmodule

`default_nettype wire

// ===== hw/rtl/websocket_frame_deframer_top.sv =====
// ---------------------------------------------------------------------------
// WebSocket frame deframer
// Parses a received byte stream into unmasked text payload beats.
// ---------------------------------------------------------------------------
// Takes one stream byte per beat on req_ and returns text payload bytes on
// rsp_, unmasked, with tlast on the last beat of each frame and the frame's
// FIN bit in tuser[0]. An empty text frame yields one beat with status 1 and
// a frame of any other opcode yields a single status 2 beat at its end; its
// payload is consumed silently. The block takes one byte every cycle while
// the response side does not stall: each byte passes through one parse step
// between the input register and the result register, so its result is
// presented on rsp_ from the result register, and a stalled response side
// backs up the request side only once both registers are full.
`timescale 1ns / 1ps
`default_nettype none

module websocket_frame_deframer_top (
   input  wire logic       clock,
   input  wire logic       reset,
   input  wire logic       req_tvalid,
   output logic            req_tready,
   input  wire logic [7:0] req_tdata,   // [7:0] data_byte
   output logic            rsp_tvalid,
   input  wire logic       rsp_tready,
   output logic [7:0]      rsp_tdata,   // [7:0] payload_byte
   output logic            rsp_tlast,   // end_of_frame
   output logic [2:0]      rsp_tuser    // [0] final_fragment, [2:1] frame_status
);
   import wsd_pkg::*;

   logic       byte_valid;
   logic [7:0] byte_data;
   logic       step_en;
   logic       res_valid;
   result_type res;

   // parse the held byte when the result register is free or draining
   assign step_en = byte_valid && (!rsp_tvalid || rsp_tready);

   wsd_in_stage u_in_stage (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .step_en    (step_en),
      .byte_valid (byte_valid),
      .byte_data  (byte_data)
   );

   wsd_parser u_parser (
      .clock     (clock),
      .reset     (reset),
      .step_en   (step_en),
      .byte_data (byte_data),
      .res_valid (res_valid),
      .res       (res)
   );

   wsd_out_stage u_out_stage (
      .clock      (clock),
      .reset      (reset),
      .res_valid  (res_valid),
      .res        (res),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tlast  (rsp_tlast),
      .rsp_tuser  (rsp_tuser)
   );

endmodule

`default_nettype wire

// ===== dv/testbench.sv =====
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// WebSocket frame deframer testbench
// Streams frame bytes into the deframer and checks every payload beat that
// comes back against a byte-level parser model kept in a scoreboard class.
// ---------------------------------------------------------------------------
// A directed opener sends empty text and dropped frames, a masked text frame
// and a 16-bit extended empty frame. Random frames follow with every opcode,
// random FIN and reserved bits, masked and plain payloads and all three
// length forms. A dropped continuation frame with a 16-bit length and a
// text frame with the largest 64-bit length close the stream. The sender
// works in bursts with random gaps; the receiver stalls on a rotating
// pattern and once holds off long enough to back up the request side.
module testbench;
   import wsd_pkg::*;

   localparam int CLOCK_HALF   = 5;
   localparam int CYCLE_LIMIT  = 2_000_000;
   localparam int RANDOM_BYTES = 420;
   localparam int HOLD_CYCLES  = 400;
   localparam int DRAIN_CYCLES = 20;

   // length encodings of the second header byte
   localparam int LEN_FORM_7  = 0;
   localparam int LEN_FORM_16 = 1;
   localparam int LEN_FORM_64 = 2;

   localparam logic [3:0] OP_CONT   = 4'h0;
   localparam logic [3:0] OP_BINARY = 4'h2;
   localparam logic [3:0] OP_CLOSE  = 4'h8;

   // -------------------------------------------------------------------------
   // Parser model and store of expected payload beats
   // -------------------------------------------------------------------------
   class deframe_scoreboard;
      phase_type   phase;
      logic        fin;
      logic [3:0]  opcode;
      logic        masked;
      logic [3:0]  hdr_count;
      logic [63:0] remaining;
      logic [31:0] key;
      logic [1:0]  key_idx;
      result_type  expected_beats[$];
      int          errors;
      int          beats_checked;
      int          empty_beats;
      int          drop_beats;

      function new();
         phase     = PH_HDR0;
         fin       = 1'b0;
         opcode    = 4'h0;
         masked    = 1'b0;
         hdr_count = 4'd0;
         remaining = 64'd0;
         key       = 32'd0;
         key_idx   = 2'd0;
         errors    = 0;
         beats_checked = 0;
         empty_beats   = 0;
         drop_beats    = 0;
      endfunction

      function void push_beat(logic [7:0] value, logic last, status_type status);
         result_type beat;
         beat.payload_byte   = value;
         beat.end_of_frame   = last;
         beat.final_fragment = fin;
         beat.frame_status   = status;
         expected_beats.push_back(beat);
      endfunction

      // header fully parsed: open the payload or close an empty frame
      function void header_finish();
         key_idx   = 2'd0;
         hdr_count = 4'd0;
         if (remaining != 64'd0) begin
            phase = PH_DATA;
         end else begin
            phase = PH_HDR0;
            push_beat(8'h00, 1'b1, (opcode == WS_TEXT) ? ST_EMPTY : ST_DROP);
         end
      endfunction

      function void length_finish();
         hdr_count = 4'd0;
         if (masked) begin
            phase = PH_KEY;
            key   = 32'd0;
         end else begin
            header_finish();
         end
      endfunction

      // advance the parser by one accepted stream byte
      function void note_stream_byte(logic [7:0] b);
         logic [7:0] kb;
         case (phase)
            PH_HDR1: begin
               masked    = b[7];
               remaining = 64'd0;
               hdr_count = 4'd0;
               if (b[6:0] == LEN7_EXT64) begin
                  phase = PH_EXT64;
               end else if (b[6:0] == LEN7_EXT16) begin
                  phase = PH_EXT16;
               end else begin
                  remaining = {57'd0, b[6:0]};
                  length_finish();
               end
            end
            PH_EXT16, PH_EXT64: begin
               remaining = {remaining[55:0], b};
               hdr_count = hdr_count + 4'd1;
               if (hdr_count == ((phase == PH_EXT16) ? EXT16_BYTES : EXT64_BYTES)) begin
                  if (remaining > LEN_MAX) remaining = LEN_MAX;
                  length_finish();
               end
            end
            PH_KEY: begin
               key       = {key[23:0], b};
               hdr_count = hdr_count + 4'd1;
               if (hdr_count == KEY_BYTES) header_finish();
            end
            PH_DATA: begin
               // first key byte received unmasks payload byte zero
               kb        = masked ? key[8 * (3 - key_idx) +: 8] : 8'h00;
               key_idx   = key_idx + 2'd1;
               remaining = remaining - 64'd1;
               if (remaining == 64'd0) phase = PH_HDR0;
               if (opcode == WS_TEXT) begin
                  push_beat(b ^ kb, remaining == 64'd0, ST_TEXT);
               end else if (remaining == 64'd0) begin
                  push_beat(8'h00, 1'b1, ST_DROP);
               end
            end
            default: begin
               fin    = b[7];
               opcode = b[3:0];
               phase  = PH_HDR1;
            end
         endcase
      endfunction

      // compare one returned beat with the oldest expectation
      function void check_payload_beat(result_type got);
         result_type want;
         if (expected_beats.size() == 0) begin
            $error("unexpected beat: payload_byte %0h tlast %0b status %0d",
                   got.payload_byte, got.end_of_frame, got.frame_status);
            errors++;
            return;
         end
         want = expected_beats.pop_front();
         if (got.payload_byte !== want.payload_byte) begin
            $error("payload_byte expected %0h actual %0h", want.payload_byte,
                   got.payload_byte);
            errors++;
         end
         if (got.end_of_frame !== want.end_of_frame) begin
            $error("end_of_frame expected %0b actual %0b", want.end_of_frame,
                   got.end_of_frame);
            errors++;
         end
         if (got.final_fragment !== want.final_fragment) begin
            $error("final_fragment expected %0b actual %0b", want.final_fragment,
                   got.final_fragment);
            errors++;
         end
         if (got.frame_status !== want.frame_status) begin
            $error("frame_status expected %0d actual %0d", want.frame_status,
                   got.frame_status);
            errors++;
         end
         if (want.frame_status == ST_EMPTY) empty_beats++;
         if (want.frame_status == ST_DROP) drop_beats++;
         beats_checked++;
      endfunction
   endclass

   logic       clock;
   logic       reset;
   logic       req_tvalid;
   logic       req_tready;
   logic [7:0] req_tdata;    // [7:0] data_byte
   logic       rsp_tvalid;
   logic       rsp_tready;
   logic [7:0] rsp_tdata;    // [7:0] payload_byte
   logic       rsp_tlast;    // end_of_frame
   logic [2:0] rsp_tuser;    // [0] final_fragment, [2:1] frame_status

   deframe_scoreboard sb;
   int         cycle_count = 0;
   int         bytes_sent = 0;
   int         frames_sent = 0;
   int         burst_left = 0;
   bit         gaps_on = 1'b1;

   websocket_frame_deframer_top dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tlast  (rsp_tlast),
      .rsp_tuser  (rsp_tuser)
   );

   initial begin
      clock = 1'b0;
      forever #CLOCK_HALF clock = ~clock;
   end

   // end the run if it stalls
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $error("timeout after %0d cycles, %0d beats still expected", cycle_count,
                sb.expected_beats.size());
         $display("CHECK FAILED");
         $finish;
      end
   end

   // check every accepted result beat
   always @(posedge clock) begin
      result_type got;
      if (!reset && rsp_tvalid && rsp_tready) begin
         got.payload_byte   = rsp_tdata;
         got.end_of_frame   = rsp_tlast;
         got.final_fragment = rsp_tuser[0];
         got.frame_status   = status_type'(rsp_tuser[2:1]);
         sb.check_payload_beat(got);
      end
   end

   // receiver: rotate stall patterns, hold off once for a long stretch
   initial begin
      int  rx_cycle;
      int  hold_left;
      bit  held_once;
      rx_cycle   = 0;
      hold_left  = 0;
      held_once  = 1'b0;
      rsp_tready <= 1'b0;
      forever begin
         @(negedge clock);
         rx_cycle++;
         if (!held_once && sb.beats_checked >= 40) begin
            held_once = 1'b1;
            hold_left = HOLD_CYCLES;
         end
         if (hold_left > 0) begin
            hold_left--;
            rsp_tready <= 1'b0;
         end else begin
            case ((rx_cycle / 80) % 4)
               0:       rsp_tready <= 1'b1;
               1:       rsp_tready <= 1'($urandom_range(0, 1));
               2:       rsp_tready <= ($urandom_range(0, 3) == 0);
               default: rsp_tready <= ((rx_cycle % 5) != 0);
            endcase
         end
      end
   end

   // offer one byte, inserting a random gap at the start of each burst
   task automatic send_byte(input logic [7:0] value);
      int gap;
      if (burst_left == 0) begin
         burst_left = $urandom_range(1, 16);
         gap = gaps_on ? $urandom_range(0, 6) : 0;
         if (gap > 0) begin
            req_tvalid <= 1'b0;
            repeat (gap) @(negedge clock);
         end
      end
      burst_left--;
      req_tvalid <= 1'b1;
      req_tdata  <= value;
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      sb.note_stream_byte(value);
      bytes_sent++;
      @(negedge clock);
   endtask

   // send header, optional key and body_len random payload bytes
   task automatic send_frame(input logic fin, input logic [2:0] rsv,
                             input logic [3:0] opcode, input logic masked,
                             input logic [31:0] key, input int form,
                             input logic [63:0] len, input longint body_len);
      send_byte({fin, rsv, opcode});
      case (form)
         LEN_FORM_16: begin
            send_byte({masked, LEN7_EXT16});
            send_byte(len[15:8]);
            send_byte(len[7:0]);
         end
         LEN_FORM_64: begin
            send_byte({masked, LEN7_EXT64});
            for (int i = 7; i >= 0; i--) send_byte(len[8 * i +: 8]);
         end
         default: send_byte({masked, len[6:0]});
      endcase
      if (masked) begin
         for (int i = 3; i >= 0; i--) send_byte(key[8 * i +: 8]);
      end
      for (longint i = 0; i < body_len; i++) send_byte(8'($urandom_range(0, 255)));
      frames_sent++;
   endtask

   initial begin
      int          pick;
      int          form;
      logic [63:0] len;
      logic [3:0]  opcode;
      logic        masked;
      int          random_start;
      sb = new();
      reset      <= 1'b1;
      req_tvalid <= 1'b0;
      req_tdata  <= 8'h00;
      repeat (4) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // directed: empty text, empty dropped, masked text, close, ext16 empty
      send_frame(1'b1, 3'b000, WS_TEXT, 1'b0, 32'h0, LEN_FORM_7, 64'd0, 0);
      send_frame(1'b0, 3'b111, OP_BINARY, 1'b0, 32'h0, LEN_FORM_7, 64'd0, 0);
      send_frame(1'b1, 3'b000, WS_TEXT, 1'b1, 32'hFF00_A55A, LEN_FORM_7, 64'd3, 3);
      send_frame(1'b1, 3'b010, OP_CLOSE, 1'b0, 32'h0, LEN_FORM_7, 64'd2, 2);
      send_frame(1'b0, 3'b000, WS_TEXT, 1'b0, 32'h0, LEN_FORM_16, 64'd0, 0);

      // random frames with all opcodes and length forms
      random_start = bytes_sent;
      while (bytes_sent - random_start < RANDOM_BYTES) begin
         gaps_on = ($urandom_range(0, 3) != 0);
         opcode  = ($urandom_range(0, 9) < 6) ? WS_TEXT : 4'($urandom_range(0, 15));
         masked  = 1'($urandom_range(0, 1));
         pick    = $urandom_range(0, 99);
         if (pick < 70) begin
            form = LEN_FORM_7;
            len  = ($urandom_range(0, 24) == 0) ? 64'd125 : 64'($urandom_range(0, 12));
         end else if (pick < 85) begin
            form = LEN_FORM_16;
            len  = ($urandom_range(0, 3) == 0) ? 64'($urandom_range(126, 300))
                                               : 64'($urandom_range(0, 20));
         end else begin
            form = LEN_FORM_64;
            len  = 64'($urandom_range(0, 20));
         end
         send_frame(1'($urandom_range(0, 1)), 3'($urandom_range(0, 7)), opcode, masked,
                    $urandom, form, len, longint'(len));
      end

      // dropped continuation frame with a 16-bit length, sent without gaps
      gaps_on = 1'b0;
      send_frame(1'b0, 3'b101, OP_CONT, 1'b0, 32'h0, LEN_FORM_16, 64'd40, 40);

      // largest 64-bit length: the frame stays open for the rest of the stream
      gaps_on = 1'b1;
      send_frame(1'b1, 3'b000, WS_TEXT, 1'b1, $urandom, LEN_FORM_64,
                 64'hFFFF_FFFF_FFFF_FFFF, 24);
      req_tvalid <= 1'b0;

      // drain outstanding beats, then let the pipeline settle
      while (sb.expected_beats.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);

      $display("Sent %0d stream bytes in %0d frames over %0d cycles.", bytes_sent,
               frames_sent, cycle_count);
      $display("Checked %0d beats (%0d empty text, %0d dropped), %0d mismatches.",
               sb.beats_checked, sb.empty_beats, sb.drop_beats, sb.errors);
      if (sb.errors == 0) begin
         $display("CHECK OK");
      end else begin
         $display("CHECK FAILED");
      end
      $finish;
   end

endmodule
